### hw/rtl/odo_pkg.sv
`default_nettype none
package odo_pkg;

	typedef struct packed {
		logic signed [19:0] right_turn;
		logic signed [19:0] left_turn;
	} in_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [15:0]        heading;
		logic               saturated;
	} out_t;

	// register indexes
	localparam logic REG_RADIUS = 1'b0;
	localparam logic REG_TRACK  = 1'b1;

	localparam logic [15:0] RADIUS_RST = 16'd922;
	localparam logic [15:0] TRACK_RST  = 16'd6707;

	// travel divisor: 1/256 cm times 2^-12 rad to 2^-16 m
	localparam logic [15:0] TRANS_DIV = 16'd3200;
	localparam logic [15:0] TRANS_RND = 16'd1600;

	// round(2^39/pi): 2^-24 rad to 2^-32 turn
	localparam logic [37:0] TURN_SCALE = 38'd174992710548;

	// cordic gain compensation, 0.60725 in q2.30
	localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

	localparam int IDX_W = 5;

	// arctangent of 2^-i in 2^-32 turn
	function automatic logic [31:0] atan_lut(input logic [IDX_W-1:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41721;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/odo_smul.sv
`default_nettype none
// shift-add multiplier, one multiplier bit per cycle, product mod 2^AW
module odo_smul #(
	parameter int AW = 48,
	parameter int BW = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [AW-1:0] a,
	input  wire logic [BW-1:0] b,
	output logic               busy,
	output logic [AW-1:0]      prod
);

	localparam int CW = $clog2(BW + 1);

	logic [CW-1:0] cnt_q;
	logic [AW-1:0] acc_q;
	logic [AW-1:0] a_q;
	logic [BW-1:0] b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(BW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (cnt_q != '0) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[AW-2:0], 1'b0};
			b_q <= {1'b0, b_q[BW-1:1]};
		end
	end

	assign busy = (cnt_q != '0);
	assign prod = acc_q;

endmodule
`default_nettype wire

### hw/rtl/odo_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle, unsigned
module odo_div #(
	parameter int NW = 48,
	parameter int DW = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               busy,
	output logic [NW-1:0]      quo
);

	localparam int CW = $clog2(NW + 1);

	logic [CW-1:0] cnt_q;
	logic [NW-1:0] q_q;
	logic [DW-1:0] r_q;
	logic [DW-1:0] d_q;
	logic [DW:0]   rt;
	logic          ge;

	assign rt = {r_q, q_q[NW-1]};
	assign ge = (rt >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (cnt_q != '0) begin
			r_q <= ge ? DW'(rt - {1'b0, d_q}) : rt[DW-1:0];
			q_q <= {q_q[NW-2:0], ge};
		end
	end

	assign busy = (cnt_q != '0);
	assign quo  = q_q;

endmodule
`default_nettype wire

### hw/rtl/odo_cordic.sv
`default_nettype none
// iterative cordic rotator, one micro-rotation per cycle
module odo_cordic #(
	parameter int STEPS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] ang,
	output logic             busy,
	output logic signed [33:0] sine,
	output logic signed [33:0] cosine
);

	localparam logic [odo_pkg::IDX_W-1:0] LAST = odo_pkg::IDX_W'(STEPS - 1);

	logic                        run_q;
	logic [odo_pkg::IDX_W-1:0]   i_q;
	logic signed [33:0]          x_q;
	logic signed [33:0]          y_q;
	logic signed [32:0]          z_q;
	logic                        neg_q;
	logic [31:0]                 ang_p;
	logic                        fold;
	logic [31:0]                 ang_f;
	logic signed [33:0]          xs;
	logic signed [33:0]          ys;
	logic signed [32:0]          at;

	assign ang_p = ang + 32'h4000_0000;
	assign fold  = ang_p[31];
	assign ang_f = fold ? (ang ^ 32'h8000_0000) : ang;
	assign xs    = x_q >>> i_q;
	assign ys    = y_q >>> i_q;
	assign at    = $signed({1'b0, odo_pkg::atan_lut(i_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			i_q   <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			i_q   <= '0;
		end else if (run_q) begin
			i_q <= i_q + 1'b1;
			if (i_q == LAST) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= odo_pkg::CORDIC_X0;
			y_q   <= '0;
			z_q   <= $signed({ang_f[31], ang_f});
			neg_q <= fold;
		end else if (run_q) begin
			if (!z_q[32]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign busy   = run_q;
	assign sine   = neg_q ? -y_q : y_q;
	assign cosine = neg_q ? -x_q : x_q;

endmodule
`default_nettype wire

### hw/rtl/diff_drive_odometry_update_top.sv
`default_nettype none
// Differential-drive odometry: each transfer on the input channel carries the
// right and left wheel rotation since the last sample (2^-12 rad); the block
// updates its pose and returns one result with x and y (2^-16 m, saturating,
// flag set when clipped) and the new heading (16-bit binary angle). The pose
// resets to zero; the wheel radius (index 0) and the wheel separation (index 1)
// are to be written through the config port while idle; the user must keep to
// this, the block itself does not enforce it. One item is in flight at a time
// and passes in order through a bit-serial radius multiply, a restoring
// division (travel and half turn side by side), a bit-serial scaling to
// binary angle, CORDIC_STEPS cordic iterations, a bit-serial sine/cosine
// multiply and a final sequencing step. The finished result sits in an output
// register, so the next item is taken while it waits, from the cycle in which
// the result appears.
module diff_drive_odometry_update_top #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire odo_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output odo_pkg::out_t      out_data,
	input  wire logic          cfg_we,
	input  wire logic          cfg_index,
	input  wire logic [15:0]   cfg_data
);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL1  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_SCALE = 3'd3;
	localparam logic [2:0] ST_ROT   = 3'd4;
	localparam logic [2:0] ST_MUL2  = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0]          state_q;
	logic [15:0]         radius_q;
	logic [15:0]         track_q;
	logic signed [31:0]  pose_x_q;
	logic signed [31:0]  pose_y_q;
	logic [15:0]         pose_heading_q;
	logic                out_valid_q;
	odo_pkg::out_t       out_q;

	logic                neg_t_q;
	logic                neg_h_q;
	logic [25:0]         trans_mag_q;
	logic                trans_neg_q;
	logic [15:0]         head_new_q;
	logic signed [29:0]  dx_q;
	logic signed [29:0]  dy_q;

	logic                in_xfer;
	logic                out_free;

	// unit handshakes
	logic start_mul1, start_div, start_scale, start_rot, start_mul2;
	logic busy_mt, busy_mh, busy_dt, busy_dh, busy_sc, busy_rot, busy_mx, busy_my;

	// sum and difference of the wheel turns
	logic signed [20:0]  sum_w;
	logic signed [20:0]  diff_w;
	logic [36:0]         prod_t;
	logic [47:0]         prod_h;
	logic [36:0]         mag_t;
	logic [47:0]         mag_h;
	logic [15:0]         base_w;
	logic [47:0]         num_t;
	logic [47:0]         num_h;
	logic [47:0]         quo_t;
	logic [47:0]         quo_h;
	logic [63:0]         half_w;
	logic [63:0]         scale_prod;
	logic [31:0]         half32;
	logic [31:0]         h32;
	logic [31:0]         mid;
	logic [31:0]         head_sum;
	logic signed [33:0]  sine;
	logic signed [33:0]  cosine;
	logic [59:0]         px;
	logic [59:0]         py;
	logic [59:0]         rx;
	logic [59:0]         ry;
	logic signed [33:0]  sx;
	logic signed [33:0]  sy;
	logic                ovf_x;
	logic                ovf_y;

	localparam logic [59:0] RND30 = 60'd536870912;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign sum_w  = {in_data.right_turn[19], in_data.right_turn}
		+ {in_data.left_turn[19], in_data.left_turn};
	assign diff_w = {in_data.right_turn[19], in_data.right_turn}
		- {in_data.left_turn[19], in_data.left_turn};

	// each stage starts when the previous unit drains
	assign start_mul1  = in_xfer;
	assign start_div   = (state_q == ST_MUL1) && !busy_mt && !busy_mh;
	assign start_scale = (state_q == ST_DIV) && !busy_dt && !busy_dh;
	assign start_rot   = (state_q == ST_SCALE) && !busy_sc;
	assign start_mul2  = (state_q == ST_ROT) && !busy_rot;

	// rounding divisions work on magnitudes, sign restored afterwards
	assign mag_t  = prod_t[36] ? -prod_t : prod_t;
	assign mag_h  = prod_h[47] ? -prod_h : prod_h;
	assign base_w = (track_q == 16'd0) ? 16'd1 : track_q;
	assign num_t  = 48'(mag_t) + 48'(odo_pkg::TRANS_RND);
	assign num_h  = mag_h + 48'(base_w[15:1]);

	assign half_w = neg_h_q ? -{16'd0, quo_h} : {16'd0, quo_h};

	// half change as binary angle in 2^-32 turn
	assign half32   = scale_prod[63:32];
	assign h32      = {pose_heading_q, 16'd0};
	assign mid      = h32 + half32;
	assign head_sum = h32 + {half32[30:0], 1'b0} + 32'h0000_8000;

	// floor((trans * s + 2^29) / 2^30), negative travel folded into the subtract
	assign rx = trans_neg_q ? (RND30 - px) : (px + RND30);
	assign ry = trans_neg_q ? (RND30 - py) : (py + RND30);

	assign sx    = {{2{pose_x_q[31]}}, pose_x_q} + {{4{dx_q[29]}}, dx_q};
	assign sy    = {{2{pose_y_q[31]}}, pose_y_q} + {{4{dy_q[29]}}, dy_q};
	assign ovf_x = (sx[33:31] != 3'b000) && (sx[33:31] != 3'b111);
	assign ovf_y = (sy[33:31] != 3'b000) && (sy[33:31] != 3'b111);

	odo_smul #(.AW(37), .BW(16)) u_mul_t (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start_mul1),
		.a     ({{16{sum_w[20]}}, sum_w}),
		.b     (radius_q),
		.busy  (busy_mt),
		.prod  (prod_t)
	);

	// difference pre-shifted by 11 for the 2^-24 rad scale
	odo_smul #(.AW(48), .BW(16)) u_mul_h (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start_mul1),
		.a     ({{16{diff_w[20]}}, diff_w, 11'd0}),
		.b     (radius_q),
		.busy  (busy_mh),
		.prod  (prod_h)
	);

	odo_div #(.NW(48), .DW(16)) u_div_t (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start_div),
		.num   (num_t),
		.den   (odo_pkg::TRANS_DIV),
		.busy  (busy_dt),
		.quo   (quo_t)
	);

	odo_div #(.NW(48), .DW(16)) u_div_h (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start_div),
		.num   (num_h),
		.den   (base_w),
		.busy  (busy_dh),
		.quo   (quo_h)
	);

	odo_smul #(.AW(64), .BW(38)) u_scale (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start_scale),
		.a     (half_w),
		.b     (odo_pkg::TURN_SCALE),
		.busy  (busy_sc),
		.prod  (scale_prod)
	);

	odo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start_rot),
		.ang   (mid),
		.busy  (busy_rot),
		.sine  (sine),
		.cosine(cosine)
	);

	odo_smul #(.AW(60), .BW(26)) u_mul_x (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start_mul2),
		.a     ({{26{sine[33]}}, sine}),
		.b     (trans_mag_q),
		.busy  (busy_mx),
		.prod  (px)
	);

	odo_smul #(.AW(60), .BW(26)) u_mul_y (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start_mul2),
		.a     ({{26{cosine[33]}}, cosine}),
		.b     (trans_mag_q),
		.busy  (busy_my),
		.prod  (py)
	);

	// sequencer, pose and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			radius_q       <= odo_pkg::RADIUS_RST;
			track_q        <= odo_pkg::TRACK_RST;
			pose_x_q       <= '0;
			pose_y_q       <= '0;
			pose_heading_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					odo_pkg::REG_RADIUS: radius_q <= cfg_data;
					odo_pkg::REG_TRACK:  track_q  <= cfg_data;
					default: ;
				endcase
			end
			// a new result replaces a taken one in the same cycle
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					if (start_div) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (start_scale) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					if (start_rot) begin
						state_q <= ST_ROT;
					end
				end
				ST_ROT: begin
					if (start_mul2) begin
						state_q <= ST_MUL2;
					end
				end
				ST_MUL2: begin
					if (!busy_mx && !busy_my) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold until the previous result has been taken
					if (out_free) begin
						pose_x_q       <= ovf_x ? (sx[33] ? 32'sh8000_0000 : 32'sh7fff_ffff)
							: sx[31:0];
						pose_y_q       <= ovf_y ? (sy[33] ? 32'sh8000_0000 : 32'sh7fff_ffff)
							: sy[31:0];
						pose_heading_q <= head_new_q;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath holding registers
	always_ff @(posedge clk) begin
		if (start_div) begin
			neg_t_q <= prod_t[36];
			neg_h_q <= prod_h[47];
		end
		if (start_scale) begin
			trans_mag_q <= quo_t[25:0];
			trans_neg_q <= neg_t_q;
		end
		if (start_rot) begin
			head_new_q <= head_sum[31:16];
		end
		if ((state_q == ST_MUL2) && !busy_mx && !busy_my) begin
			dx_q <= $signed(rx[59:30]);
			dy_q <= $signed(ry[59:30]);
		end
		if ((state_q == ST_FIN) && out_free) begin
			out_q.pos_x     <= ovf_x ? (sx[33] ? 32'sh8000_0000 : 32'sh7fff_ffff) : sx[31:0];
			out_q.pos_y     <= ovf_y ? (sy[33] ? 32'sh8000_0000 : 32'sh7fff_ffff) : sy[31:0];
			out_q.heading   <= head_new_q;
			out_q.saturated <= ovf_x || ovf_y;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

### hw/rtl/odo_chk.sv
`default_nettype none
module odo_chk (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_ready,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire odo_pkg::out_t out_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped or changed while stalled");

	// one item at a time
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in flight");

	// a new result appears only as the block returns to idle
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result raised while busy");

	// saturation flag means a coordinate sits at a limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |->
			(out_data.pos_x == 32'sh7fff_ffff) || (out_data.pos_x == 32'sh8000_0000) ||
			(out_data.pos_y == 32'sh7fff_ffff) || (out_data.pos_y == 32'sh8000_0000))
		else $error("saturated flag without clipped coordinate");

endmodule

bind diff_drive_odometry_update_top odo_chk u_odo_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);
`default_nettype wire

### bench/diff_drive_odometry_update_top_tb.sv
`timescale 1ns / 1ps
module diff_drive_odometry_update_top_tb;

	localparam int STEPS = 16;
	localparam int IDLE_LIMIT = 6000;
	localparam logic [63:0] ANGLE_SCALE = 64'd174992710548;
	localparam longint GAIN_X0 = 64'sd652032874;

	// arctangent of 2^-i, 2^-32 turn
	localparam logic [31:0] ATAN_TURN [0:23] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	odo_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	odo_pkg::out_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_index = odo_pkg::REG_RADIUS;
	logic [15:0] cfg_data = '0;

	// predictor copy of geometry and pose
	logic [15:0] radius_q = odo_pkg::RADIUS_RST;
	logic [15:0] base_q = odo_pkg::TRACK_RST;
	logic signed [31:0] pose_x_q = '0;
	logic signed [31:0] pose_y_q = '0;
	logic [15:0] heading_q = '0;

	odo_pkg::out_t expected_pose[$];
	int mismatches = 0;
	int results_seen = 0;
	int items_sent = 0;
	int saturations = 0;
	int idle_cycles = 0;

	// sender burst shaping
	int burst_left = 0;
	int gap_max = 8;
	// receiver stall pattern
	int stall_mode = 0;
	int stall_cnt = 0;

	always #5 clk = ~clk;

	diff_drive_odometry_update_top #(.CORDIC_STEPS(STEPS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// signed divide with rounding half away from zero
	function automatic longint div_half_away(input longint n, input longint d);
		longint mag;
		longint q;
		mag = (n < 0) ? -n : n;
		q = (mag + d / 2) / d;
		return (n < 0) ? -q : q;
	endfunction

	// sine and cosine of a 2^-32 turn angle, q2.30
	task automatic rotate_vector(input logic [31:0] ang, output longint sn, output longint cs);
		logic flip;
		longint x;
		longint y;
		longint z;
		longint t;
		flip = 1'b0;
		x = GAIN_X0;
		y = 0;
		// fold into the right half plane, negate afterwards
		if (((ang + 32'h4000_0000) & 32'h8000_0000) != 0) begin
			ang = ang ^ 32'h8000_0000;
			flip = 1'b1;
		end
		z = longint'($signed(ang));
		for (int i = 0; i < STEPS; i++) begin
			if (z >= 0) begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				z = z - longint'(ATAN_TURN[i]);
			end else begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				z = z + longint'(ATAN_TURN[i]);
			end
			x = t;
		end
		sn = flip ? -y : y;
		cs = flip ? -x : x;
	endtask

	task automatic clip_add(input logic signed [31:0] a, input longint b,
			output logic signed [31:0] sum, inout logic flag);
		longint s;
		s = longint'(a) + b;
		if (s > 64'sd2147483647) begin
			sum = 32'sh7fff_ffff;
			flag = 1'b1;
		end else if (s < -64'sd2147483648) begin
			sum = 32'sh8000_0000;
			flag = 1'b1;
		end else begin
			sum = s[31:0];
		end
	endtask

	// advance the predicted pose by one wheel sample and queue the result
	task automatic update_pose(input odo_pkg::in_t item);
		longint r;
		longint l;
		longint rad;
		longint base;
		longint trans;
		longint half;
		longint sn;
		longint cs;
		longint dx;
		longint dy;
		logic [63:0] prod;
		logic [31:0] half32;
		logic [31:0] h32;
		logic [31:0] hnew;
		logic clipped;
		odo_pkg::out_t res;
		r = longint'(item.right_turn);
		l = longint'(item.left_turn);
		rad = longint'(radius_q);
		base = (base_q == 0) ? 1 : longint'(base_q);
		clipped = 1'b0;
		trans = div_half_away((r + l) * rad, 3200);
		half = div_half_away((r - l) * rad * 2048, base);
		prod = 64'(half) * ANGLE_SCALE;
		half32 = prod[63:32];
		h32 = {heading_q, 16'h0000};
		rotate_vector(h32 + half32, sn, cs);
		dx = (trans * sn + (64'sd1 <<< 29)) >>> 30;
		dy = (trans * cs + (64'sd1 <<< 29)) >>> 30;
		clip_add(pose_x_q, dx, pose_x_q, clipped);
		clip_add(pose_y_q, dy, pose_y_q, clipped);
		hnew = h32 + 2 * half32 + 32'h8000;
		heading_q = hnew[31:16];
		res.pos_x = pose_x_q;
		res.pos_y = pose_y_q;
		res.heading = heading_q;
		res.saturated = clipped;
		if (clipped)
			saturations++;
		expected_pose.push_back(res);
	endtask

	// one transfer on the input channel; valid stays up within a burst
	task automatic send_turns(input logic signed [19:0] right, input logic signed [19:0] left);
		odo_pkg::in_t item;
		int gap;
		item.right_turn = right;
		item.left_turn = left;
		if (burst_left == 0) begin
			gap = (gap_max > 0) ? int'($urandom_range(0, gap_max)) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
		update_pose(item);
		items_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	// stop sending and let every pending result drain
	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_pose.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// both geometry registers, only called while drained
	task automatic set_geometry(input logic [15:0] radius, input logic [15:0] base);
		cfg_we <= 1'b1;
		cfg_index <= odo_pkg::REG_RADIUS;
		cfg_data <= radius;
		@(negedge clk);
		cfg_index <= odo_pkg::REG_TRACK;
		cfg_data <= base;
		@(negedge clk);
		cfg_we <= 1'b0;
		radius_q = radius;
		base_q = base;
	endtask

	// wheel sample: mostly realistic motion, some full-range noise and extremes
	task automatic random_turns(output logic signed [19:0] right, output logic signed [19:0] left);
		int pick;
		int fwd;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			fwd = $urandom_range(0, 4000) - 2000;
			right = 20'(fwd + int'($urandom_range(0, 400)) - 200);
			left = 20'(fwd + int'($urandom_range(0, 400)) - 200);
		end else if (pick < 80) begin
			right = 20'($urandom);
			left = 20'($urandom);
		end else if (pick < 90) begin
			right = $urandom_range(0, 1) ? 20'sh7ffff : 20'sh80000;
			left = $urandom_range(0, 1) ? 20'sh7ffff : 20'sh80000;
		end else begin
			// pure spin in place
			fwd = $urandom_range(0, 65535) - 32768;
			right = 20'(fwd);
			left = 20'(-fwd);
		end
	endtask

	task automatic test_directed();
		// extremes of both fields, straight runs, spins and tiny turns
		send_turns(20'sd0, 20'sd0);
		send_turns(20'sh7ffff, 20'sh7ffff);
		send_turns(20'sh80000, 20'sh80000);
		send_turns(20'sh7ffff, 20'sh80000);
		send_turns(20'sh80000, 20'sh7ffff);
		send_turns(20'sd1, -20'sd1);
		send_turns(-20'sd1, 20'sd1);
		send_turns(20'sd1, 20'sd0);
		send_turns(20'sd4096, 20'sd4096);
		send_turns(20'sd20000, -20'sd20000);
		send_turns(20'sd3000, 20'sd2900);
		send_turns(-20'sd5000, -20'sd5200);
		send_turns(20'sh55555, 20'shaaaaa);
		send_turns(20'shaaaaa, 20'sh55555);
		drain_results();
		// zero radius: no travel and no turn
		set_geometry(16'd0, 16'd6707);
		send_turns(20'sh7ffff, 20'sh80000);
		send_turns(20'sd12345, 20'sd999);
		drain_results();
		// zero base is treated as one, half change wraps many turns
		set_geometry(16'd65535, 16'd0);
		send_turns(20'sd1000, -20'sd1000);
		send_turns(20'sh7ffff, 20'sh80000);
		send_turns(20'sd7, 20'sd3);
		drain_results();
	endtask

	// random phase at one geometry setting
	task automatic test_random_phase(input logic [15:0] radius, input logic [15:0] base,
			input int count, input bit drive_hard);
		logic signed [19:0] right;
		logic signed [19:0] left;
		set_geometry(radius, base);
		gap_max = $urandom_range(0, 1) ? 0 : $urandom_range(1, 30);
		for (int n = 0; n < count; n++) begin
			if (n % 100 == 50)
				gap_max = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 30);
			random_turns(right, left);
			// long straight pushes run the pose into its range limits
			if (drive_hard && $urandom_range(0, 3) != 0) begin
				right = $urandom_range(0, 1) ? 20'sh7ffff : 20'sh80000;
				left = right + 20'(int'($urandom_range(0, 16)) - 8);
			end
			send_turns(right, left);
		end
		drain_results();
	endtask

	task automatic test_geometry_sweep();
		test_random_phase(odo_pkg::RADIUS_RST, odo_pkg::TRACK_RST, 300, 1'b0);
		test_random_phase(16'd65535, 16'd65535, 300, 1'b1);
		test_random_phase(16'd1, 16'd65535, 150, 1'b0);
		test_random_phase(16'd65535, 16'd1, 200, 1'b0);
		test_random_phase(16'(($urandom_range(1, 65535))), 16'($urandom_range(1, 65535)),
			250, 1'b0);
		test_random_phase(16'd65535, 16'd300, 250, 1'b1);
		test_random_phase(16'($urandom_range(100, 3000)), 16'($urandom_range(1000, 20000)),
			250, 1'b0);
	endtask

	// receiver: each mode holds for a while, one of them never stalls
	always @(negedge clk) begin
		if (stall_cnt == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_cnt <= $urandom_range(50, 400);
		end else begin
			stall_cnt <= stall_cnt - 1;
		end
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= (stall_cnt % 7) < 3;
		endcase
	end

	// result checker: every transfer is compared with the oldest prediction
	always @(posedge clk) begin
		odo_pkg::out_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_pose.size() == 0) begin
				$display("%t unexpected result x=%0d y=%0d heading=%0d sat=%0b", $realtime,
					out_data.pos_x, out_data.pos_y, out_data.heading, out_data.saturated);
				mismatches++;
			end else begin
				exp_res = expected_pose.pop_front();
				if (out_data.pos_x !== exp_res.pos_x) begin
					$display("%t pos_x expected %0d actual %0d", $realtime,
						exp_res.pos_x, out_data.pos_x);
					mismatches++;
				end
				if (out_data.pos_y !== exp_res.pos_y) begin
					$display("%t pos_y expected %0d actual %0d", $realtime,
						exp_res.pos_y, out_data.pos_y);
					mismatches++;
				end
				if (out_data.heading !== exp_res.heading) begin
					$display("%t heading expected %0d actual %0d", $realtime,
						exp_res.heading, out_data.heading);
					mismatches++;
				end
				if (out_data.saturated !== exp_res.saturated) begin
					$display("%t saturated expected %0b actual %0b", $realtime,
						exp_res.saturated, out_data.saturated);
					mismatches++;
				end
			end
		end
	end

	// watchdog: too long without any transfer ends the run
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%t watchdog expired with %0d results pending", $realtime,
				expected_pose.size());
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		test_directed();
		test_geometry_sweep();
		drain_results();
		repeat (200) @(negedge clk);
		if (expected_pose.size() != 0) begin
			$display("%t %0d results never arrived", $realtime, expected_pose.size());
			mismatches++;
		end
		$display("covered %0d wheel samples, %0d results, %0d saturating steps",
			items_sent, results_seen, saturations);
		$display("geometry sweep included zero radius, zero base and both register extremes");
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/odo_pkg.sv
hw/rtl/odo_smul.sv
hw/rtl/odo_div.sv
hw/rtl/odo_cordic.sv
hw/rtl/diff_drive_odometry_update_top.sv
hw/rtl/odo_chk.sv
bench/diff_drive_odometry_update_top_tb.sv
